### rtl/core/ipv4enc_pkg.sv
// Shared types, constants and helper functions for the IPv4-in-TCP encapsulator.
// Used by every module under rtl/core; depends on nothing.
package ipv4enc_pkg;

    localparam int DEFAULT_MTU  = 1500;
    localparam int HEAD_LEN     = 20;
    localparam int HDR_BYTES    = 40;
    localparam int CMD_DEPTH    = 4;
    localparam int CMD_PTR_W    = $clog2(CMD_DEPTH);

    localparam logic [7:0]  VER_IHL      = 8'h45;
    localparam logic [7:0]  PROTO_TCP    = 8'h06;
    localparam logic [15:0] ENCAP_EXTRA  = 16'd40;
    localparam logic [19:0] IP_SUM_BASE  = 20'h0452E;
    localparam logic [19:0] TCP_SUM_BASE = 20'h15219;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_MTU   = 2'd2;

    localparam logic [2:0] REG_PROXY_IP = 3'd0;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] packet_len;
        logic        in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       out_last;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_ERR,
        CMD_HDR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [1:0]  status;
        logic [7:0]  data;
        logic        last;
        logic [15:0] tot_len;
        logic [19:0] ip_sum;
        logic [19:0] tcp_sum;
    } cmd_t;

    function automatic logic [15:0] csum_fold(input logic [19:0] raw);
        logic [16:0] s;
        logic [15:0] r;
        s = {1'b0, raw[15:0]} + {13'd0, raw[19:16]};
        r = s[15:0] + {15'd0, s[16]};
        return ~r;
    endfunction

    function automatic logic [7:0] tcp_const(input logic [5:0] idx);
        logic [7:0] v;
        case (idx)
            6'd24:   v = 8'h01;
            6'd28:   v = 8'h01;
            6'd32:   v = 8'h50;
            6'd34:   v = 8'hFF;
            6'd35:   v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic ip_sum_pos(input logic [4:0] pos);
        logic v;
        case (pos)
            5'd1, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
            5'd12, 5'd13, 5'd14, 5'd15: v = 1'b1;
            default:                    v = 1'b0;
        endcase
        return v;
    endfunction

    function automatic logic tcp_sum_pos(input logic [4:0] pos);
        logic v;
        case (pos)
            5'd12, 5'd13, 5'd14, 5'd15: v = 1'b1;
            default:                    v = 1'b0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/ipv4enc_front.sv
// Front end: accepts input beats, holds the first 20 bytes, classifies each beat
// and emits pass, error and header commands. Depends on ipv4enc_pkg.
module ipv4enc_front #(
    parameter int MAX_TRANSFER_UNIT = ipv4enc_pkg::DEFAULT_MTU
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  ipv4enc_pkg::in_item_t item,
    input  logic [16:0]          proxy_sum,
    input  logic                 cmd_full,
    output logic                 cmd_push,
    output ipv4enc_pkg::cmd_t    cmd,
    input  logic                 hdr_done,
    input  logic [4:0]           buf_addr,
    output logic [7:0]           buf_data
);

    localparam logic [16:0] LEN_LIMIT = 17'(MAX_TRANSFER_UNIT - 40);

    logic [7:0]  head_reg [ipv4enc_pkg::HEAD_LEN];
    logic [4:0]  pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic        rejected_reg, rejected_next;
    logic        pending_reg, pending_next;
    logic [19:0] ip_acc_reg, ip_acc_next;
    logic [19:0] tcp_acc_reg, tcp_acc_next;

    logic        accept;
    logic        head_wr;
    logic [19:0] byte_term;
    logic [19:0] ip_base;
    logic [19:0] tcp_base;
    logic [15:0] cur_len;

    assign full   = cmd_full
                  || (pending_reg && !rejected_reg && (pos_reg < 5'(ipv4enc_pkg::HEAD_LEN)));
    assign accept = push && !full;
    assign buf_data = head_reg[buf_addr];

    assign cur_len   = (pos_reg == 5'd0) ? item.packet_len : len_reg;
    assign byte_term = pos_reg[0] ? {12'd0, item.data_byte} : {4'd0, item.data_byte, 8'd0};
    assign ip_base   = (pos_reg == 5'd0)
                     ? ipv4enc_pkg::IP_SUM_BASE + {4'd0, item.packet_len} + {3'd0, proxy_sum}
                     : ip_acc_reg;
    assign tcp_base  = (pos_reg == 5'd0)
                     ? ipv4enc_pkg::TCP_SUM_BASE + {3'd0, proxy_sum}
                     : tcp_acc_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        len_next      = len_reg;
        rejected_next = rejected_reg;
        pending_next  = pending_reg;
        ip_acc_next   = ip_acc_reg;
        tcp_acc_next  = tcp_acc_reg;
        head_wr       = 1'b0;
        cmd_push      = 1'b0;
        cmd.kind      = ipv4enc_pkg::CMD_PASS;
        cmd.status    = ipv4enc_pkg::ST_OK;
        cmd.data      = item.data_byte;
        cmd.last      = item.in_last;
        cmd.tot_len   = cur_len + ipv4enc_pkg::ENCAP_EXTRA;
        cmd.ip_sum    = ip_acc_next;
        cmd.tcp_sum   = tcp_acc_next;

        if (hdr_done)
        begin
            pending_next = 1'b0;
        end

        if (accept)
        begin
            if (rejected_reg)
            begin
                if (item.in_last)
                begin
                    rejected_next = 1'b0;
                    pos_next      = 5'd0;
                end
            end
            else if ((pos_reg == 5'd0)
                     && ((item.packet_len < 16'(ipv4enc_pkg::HEAD_LEN))
                         || ({1'b0, item.packet_len} > LEN_LIMIT)))
            begin
                len_next   = item.packet_len;
                cmd_push   = 1'b1;
                cmd.kind   = ipv4enc_pkg::CMD_ERR;
                cmd.status = (item.packet_len < 16'(ipv4enc_pkg::HEAD_LEN))
                           ? ipv4enc_pkg::ST_SHORT : ipv4enc_pkg::ST_MTU;
                cmd.last   = 1'b1;
                rejected_next = !item.in_last;
            end
            else if (pos_reg >= 5'(ipv4enc_pkg::HEAD_LEN))
            begin
                cmd_push = 1'b1;
                if (item.in_last)
                begin
                    pos_next = 5'd0;
                end
            end
            else
            begin
                head_wr      = 1'b1;
                len_next     = cur_len;
                ip_acc_next  = ipv4enc_pkg::ip_sum_pos(pos_reg) ? ip_base + byte_term : ip_base;
                tcp_acc_next = ipv4enc_pkg::tcp_sum_pos(pos_reg)
                             ? tcp_base + byte_term : tcp_base;
                cmd.ip_sum   = ip_acc_next;
                cmd.tcp_sum  = tcp_acc_next;
                if (pos_reg == 5'(ipv4enc_pkg::HEAD_LEN - 1))
                begin
                    cmd_push     = 1'b1;
                    cmd.kind     = ipv4enc_pkg::CMD_HDR;
                    pending_next = 1'b1;
                    pos_next     = item.in_last ? 5'd0 : 5'(ipv4enc_pkg::HEAD_LEN);
                end
                else if (item.in_last)
                begin
                    cmd_push   = 1'b1;
                    cmd.kind   = ipv4enc_pkg::CMD_ERR;
                    cmd.status = ipv4enc_pkg::ST_SHORT;
                    pos_next   = 5'd0;
                end
                else
                begin
                    pos_next = pos_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 5'd0;
            len_reg      <= 16'd0;
            rejected_reg <= 1'b0;
            pending_reg  <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            rejected_reg <= rejected_next;
            pending_reg  <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_acc_reg  <= ip_acc_next;
        tcp_acc_reg <= tcp_acc_next;
        if (head_wr)
        begin
            head_reg[pos_reg] <= item.data_byte;
        end
    end

endmodule

### rtl/core/ipv4enc_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on ipv4enc_pkg for the command type and depth.
module ipv4enc_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  ipv4enc_pkg::cmd_t wr_cmd,
    output logic              full,
    input  logic              rd,
    output ipv4enc_pkg::cmd_t rd_cmd,
    output logic              empty
);

    localparam int PW = ipv4enc_pkg::CMD_PTR_W;

    ipv4enc_pkg::cmd_t mem_reg [ipv4enc_pkg::CMD_DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [PW:0]   count_reg;
    logic          do_wr, do_rd;

    assign full   = (count_reg == (PW+1)'(ipv4enc_pkg::CMD_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;
    assign rd_cmd = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PW+1)'(do_wr) - (PW+1)'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_cmd;
        end
    end

endmodule

### rtl/core/ipv4enc_back.sv
// Back end: carries out queued commands, building the 40 header bytes and
// replaying the held bytes into the output register. Depends on ipv4enc_pkg.
module ipv4enc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ipv4enc_pkg::cmd_t      cmd,
    input  logic                   cmd_empty,
    output logic                   cmd_pop,
    output logic                   hdr_done,
    output logic [4:0]             buf_addr,
    input  logic [7:0]             buf_data,
    input  logic [31:0]            proxy_ip,
    output logic                   empty,
    input  logic                   pop,
    output ipv4enc_pkg::out_item_t result
);

    localparam logic [5:0] LAST_IDX = 6'(ipv4enc_pkg::HDR_BYTES + ipv4enc_pkg::HEAD_LEN - 1);

    logic [5:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    ipv4enc_pkg::out_item_t res_reg, res_next;

    logic        adv;
    logic [5:0]  idx_back;
    logic [15:0] ip_ck;
    logic [15:0] tcp_ck;
    logic [7:0]  hdr_byte;

    assign empty    = !valid_reg;
    assign result   = res_reg;
    assign adv      = !cmd_empty && (!valid_reg || pop);
    assign idx_back = idx_reg - 6'(ipv4enc_pkg::HDR_BYTES);
    assign buf_addr = (idx_reg < 6'(ipv4enc_pkg::HEAD_LEN)) ? idx_reg[4:0] : idx_back[4:0];
    assign ip_ck    = ipv4enc_pkg::csum_fold(cmd.ip_sum);
    assign tcp_ck   = ipv4enc_pkg::csum_fold(cmd.tcp_sum);

    always_comb
    begin
        case (idx_reg)
            6'd0:    hdr_byte = ipv4enc_pkg::VER_IHL;
            6'd2:    hdr_byte = cmd.tot_len[15:8];
            6'd3:    hdr_byte = cmd.tot_len[7:0];
            6'd9:    hdr_byte = ipv4enc_pkg::PROTO_TCP;
            6'd10:   hdr_byte = ip_ck[15:8];
            6'd11:   hdr_byte = ip_ck[7:0];
            6'd16:   hdr_byte = proxy_ip[31:24];
            6'd17:   hdr_byte = proxy_ip[23:16];
            6'd18:   hdr_byte = proxy_ip[15:8];
            6'd19:   hdr_byte = proxy_ip[7:0];
            6'd36:   hdr_byte = tcp_ck[15:8];
            6'd37:   hdr_byte = tcp_ck[7:0];
            default:
            begin
                if ((idx_reg >= 6'(ipv4enc_pkg::HEAD_LEN))
                    && (idx_reg < 6'(ipv4enc_pkg::HDR_BYTES)))
                begin
                    hdr_byte = ipv4enc_pkg::tcp_const(idx_reg);
                end
                else
                begin
                    hdr_byte = buf_data;
                end
            end
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        cmd_pop    = 1'b0;
        hdr_done   = 1'b0;

        if (pop)
        begin
            valid_next = 1'b0;
        end

        if (adv)
        begin
            valid_next = 1'b1;
            case (cmd.kind)
                ipv4enc_pkg::CMD_PASS:
                begin
                    res_next.out_byte = cmd.data;
                    res_next.status   = ipv4enc_pkg::ST_OK;
                    res_next.out_last = cmd.last;
                    cmd_pop           = 1'b1;
                end
                ipv4enc_pkg::CMD_ERR:
                begin
                    res_next.out_byte = 8'd0;
                    res_next.status   = cmd.status;
                    res_next.out_last = 1'b1;
                    cmd_pop           = 1'b1;
                end
                ipv4enc_pkg::CMD_HDR:
                begin
                    res_next.out_byte = hdr_byte;
                    res_next.status   = ipv4enc_pkg::ST_OK;
                    res_next.out_last = (idx_reg == LAST_IDX) && cmd.last;
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next = 6'd0;
                        cmd_pop  = 1'b1;
                        hdr_done = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
                default:
                begin
                    cmd_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 6'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

### rtl/core/ipv4_tcp_header_encapsulator.sv
// Top level of the IPv4-in-TCP header encapsulator: configuration register,
// front end, command queue and back end. Depends on ipv4enc_pkg and ipv4enc_*.
//
//   channel   handshake            payload
//   item      push / full          in_item_t  {data_byte, packet_len, in_last}
//   result    empty / pop          out_item_t {out_byte, status, out_last}
//   config    psel/penable/pwrite  proxy_ip at byte address 0
//
// Pass-through beats move at one per cycle. The first 20 bytes of a packet are
// held; the 20th queues a header command that the back end plays out as 60 result
// beats, one per cycle as popped, through a single output register. Input stalls
// while that replay reads the held bytes and a new packet's head arrives, or the
// queue is full. Reset clears all control state; no clearing pass is needed.
module ipv4_tcp_header_encapsulator #(
    parameter int MAX_TRANSFER_UNIT = ipv4enc_pkg::DEFAULT_MTU
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  ipv4enc_pkg::in_item_t  item,
    output logic                   empty,
    input  logic                   pop,
    output ipv4enc_pkg::out_item_t result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [31:0]       proxy_ip_reg;
    logic [16:0]       proxy_sum;
    logic              cmd_full, cmd_empty, cmd_push, cmd_pop;
    logic              hdr_done;
    logic [4:0]        buf_addr;
    logic [7:0]        buf_data;
    ipv4enc_pkg::cmd_t wr_cmd, rd_cmd;

    assign pready    = 1'b1;
    assign prdata    = (paddr == ipv4enc_pkg::REG_PROXY_IP) ? proxy_ip_reg : 32'd0;
    assign proxy_sum = {1'b0, proxy_ip_reg[31:16]} + {1'b0, proxy_ip_reg[15:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proxy_ip_reg <= 32'd0;
        end
        else if (psel && penable && pwrite && (paddr == ipv4enc_pkg::REG_PROXY_IP))
        begin
            proxy_ip_reg <= pwdata;
        end
    end

    ipv4enc_front #(
        .MAX_TRANSFER_UNIT(MAX_TRANSFER_UNIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .proxy_sum(proxy_sum),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (wr_cmd),
        .hdr_done (hdr_done),
        .buf_addr (buf_addr),
        .buf_data (buf_data)
    );

    ipv4enc_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_push),
        .wr_cmd(wr_cmd),
        .full  (cmd_full),
        .rd    (cmd_pop),
        .rd_cmd(rd_cmd),
        .empty (cmd_empty)
    );

    ipv4enc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (rd_cmd),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .hdr_done (hdr_done),
        .buf_addr (buf_addr),
        .buf_data (buf_data),
        .proxy_ip (proxy_ip_reg),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule
